### rtl/core/dclru_pkg.sv
// Package: shared types and constants for the LRU write-back cache timing model.
`timescale 1ns / 1ps
package dclru_pkg;

	localparam int AddrW = 48;
	localparam int CfgW  = 16;

	typedef enum logic [0:0] {
		CFG_LINE_SHIFT   = 1'b0,
		CFG_MISS_PENALTY = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [AddrW-1:0] now_cycle;
		logic [AddrW-1:0] byte_addr;
		logic             is_store;
	} req_t;

	typedef struct packed {
		logic [AddrW-1:0] ready_cycle;
		logic             hit;
		logic             dirty_evict;
		logic [AddrW-1:0] victim_line;
	} resp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic capture;
		logic update;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

### rtl/core/dclru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module dclru_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/dclru_ctrl.sv
// Controller: clearing pass after reset, then read / update per access.
`timescale 1ns / 1ps
module dclru_ctrl import dclru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy,
	output logic done
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (start) state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR:  ctl.clr_en = 1'b1;
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			ST_READ:   ;
			ST_UPDATE: begin
				ctl.update = 1'b1;
				done       = 1'b1;
			end
			default:   ;
		endcase
	end
endmodule

### rtl/core/dclru_dp.sv
// Datapath: per-set row memory, tag compare, LRU update and result build.
`timescale 1ns / 1ps
module dclru_dp import dclru_pkg::*; #(
	parameter int Ways = 4,
	parameter int Sets = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  req_t        req,
	input  logic [3:0]  line_shift,
	input  logic [15:0] miss_penalty,
	output resp_t       resp
);
	localparam int SetW  = (Sets > 1) ? $clog2(Sets) : 1;
	localparam int RankW = (Ways > 1) ? $clog2(Ways) : 1;
	// per way: valid, dirty, rank, tag, ready
	localparam int EntW  = 2 + RankW + 2 * AddrW;
	localparam int RowW  = Ways * EntW;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [RankW-1:0] rank;
		logic [AddrW-1:0] tag;
		logic [AddrW-1:0] ready;
	} ent_t;

	logic [SetW-1:0]  clr_q;
	logic [AddrW-1:0] line_s1, now_s1;
	logic             store_s1;
	logic [SetW-1:0]  set_s1;
	logic [RowW-1:0]  row_rd, row_wr;
	logic [SetW-1:0]  waddr, raddr;
	logic             we;
	logic [AddrW-1:0] line_c;

	assign line_c = req.byte_addr >> line_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign sts.clr_last = (clr_q == SetW'(Sets - 1));

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			line_s1  <= line_c;
			now_s1   <= req.now_cycle;
			store_s1 <= req.is_store;
			set_s1   <= (Sets > 1) ? SetW'(line_c % Sets) : '0;
		end
	end

	// Reset row: all invalid, identity ranks.
	function automatic logic [RowW-1:0] reset_row();
		ent_t e;
		logic [RowW-1:0] r;
		r = '0;
		for (int w = 0; w < Ways; w++) begin
			e       = '0;
			e.rank  = RankW'(w);
			r[w*EntW +: EntW] = e;
		end
		return r;
	endfunction

	ent_t ent   [Ways];
	ent_t upd   [Ways];
	logic [RankW-1:0] hway, vway, way;
	logic             hit;
	logic [RankW-1:0] r_acc;

	always_comb begin
		hit  = 1'b0;
		hway = '0;
		vway = '0;
		for (int w = Ways - 1; w >= 0; w--) begin
			ent[w] = row_rd[w*EntW +: EntW];
			if (ent[w].valid && ent[w].tag == line_s1) begin
				hit  = 1'b1;
				hway = RankW'(w);
			end
		end
		for (int w = 0; w < Ways; w++) begin
			if (ent[w].rank == RankW'(Ways - 1)) vway = RankW'(w);
		end
		way   = hit ? hway : vway;
		r_acc = ent[way].rank;
		for (int w = 0; w < Ways; w++) begin
			upd[w] = ent[w];
			if (ent[w].rank < r_acc) upd[w].rank = ent[w].rank + 1'b1;
		end
		if (!hit) begin
			upd[way].valid = 1'b1;
			upd[way].dirty = 1'b0;
			upd[way].tag   = line_s1;
			upd[way].ready = now_s1 + AddrW'(miss_penalty);
		end
		upd[way].rank = '0;
		if (store_s1) upd[way].dirty = 1'b1;
		for (int w = 0; w < Ways; w++) begin
			row_wr[w*EntW +: EntW] = upd[w];
		end
		resp.ready_cycle = upd[way].ready;
		resp.hit         = hit;
		resp.dirty_evict = !hit && ent[way].valid && ent[way].dirty;
		resp.victim_line = resp.dirty_evict ? ent[way].tag : '0;
	end

	assign we    = ctl.clr_en || ctl.update;
	assign waddr = ctl.clr_en ? clr_q : set_s1;
	// hold the captured set while the access is in flight; the request may move on
	assign raddr = ctl.capture ? ((Sets > 1) ? SetW'(line_c % Sets) : '0) : set_s1;

	dclru_ram #(.Width(RowW), .Depth((Sets > 1) ? Sets : 2)) u_rows (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(ctl.clr_en ? reset_row() : row_wr),
		.raddr(raddr),
		.rdata(row_rd)
	);
endmodule

### rtl/core/dcache_lru_writeback_timing.sv
// Top level: LRU write-back data cache timing model.
`timescale 1ns / 1ps
// Usage:
//  - Configuration: cfg_we with cfg_idx / cfg_data writes line_shift (index 0)
//    or miss_penalty (index 1) at once; other indices are ignored. Write only
//    while busy is low and no access is in flight.
//  - Request: an access word (now_cycle, byte_addr, is_store) is taken at a
//    clock edge where start is high and busy is low.
//  - Result: done pulses for one cycle with the result word on resp; the
//    controller raises it in its update state, after the read state. The
//    receiver cannot stall; the word is gone after that cycle.
//  - One access at a time: busy is high until the access is done. Each access
//    reads its set row from the row memory (registered read), compares,
//    updates LRU ranks and writes it back, all on the one memory port pair.
//  - Reset: arst_n clears the controller; a clearing pass then writes every
//    set row to invalid with identity LRU order, one set per cycle, while
//    busy is high. Configuration returns to line_shift 6, miss_penalty 20.
module dcache_lru_writeback_timing import dclru_pkg::*; #(
	parameter int WAYS = 4,
	parameter int SETS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            start,
	input  req_t            req,
	output logic            busy,
	output logic            done,
	output resp_t           resp
);
	logic [3:0]  line_shift_q;
	logic [15:0] miss_penalty_q;
	ctl_t        ctl;
	sts_t        sts;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_shift_q   <= 4'd6;
			miss_penalty_q <= 16'd20;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_LINE_SHIFT:   line_shift_q   <= cfg_data[3:0];
				CFG_MISS_PENALTY: miss_penalty_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	dclru_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	dclru_dp #(.Ways(WAYS), .Sets(SETS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.req         (req),
		.line_shift  (line_shift_q),
		.miss_penalty(miss_penalty_q),
		.resp        (resp)
	);
endmodule

### dv/tb_dcache_lru_writeback_timing.sv
// Testbench for the LRU write-back data cache timing model.
`timescale 1ns / 1ps
module tb_dcache_lru_writeback_timing;
	import dclru_pkg::*;

	localparam int WAYS = 4;
	localparam int SETS = 256;
	// cycles with no accepted word and no result before giving up;
	// covers the clearing pass after reset and the longest sender gap
	localparam int STALL_LIMIT = 5000;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic            cfg_idx;
	logic [CfgW-1:0] cfg_data;
	logic            start;
	req_t            req;
	logic            busy;
	logic            done;
	resp_t           resp;

	dcache_lru_writeback_timing #(
		.WAYS(WAYS),
		.SETS(SETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.resp(resp)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Cache state as the block should hold it
	logic [AddrW-1:0] way_tag   [SETS][WAYS];
	logic [AddrW-1:0] way_ready [SETS][WAYS];
	bit               way_valid [SETS][WAYS];
	bit               way_dirty [SETS][WAYS];
	int unsigned      way_rank  [SETS][WAYS];   // 0 = most recently used
	logic [3:0]       cur_shift;
	logic [15:0]      cur_penalty;

	resp_t pending_resp[$];   // results owed by the block, oldest first
	int    errors;
	int    quiet_cycles;

	function automatic void clear_cache();
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				way_tag[s][w]   = '0;
				way_ready[s][w] = '0;
				way_valid[s][w] = 1'b0;
				way_dirty[s][w] = 1'b0;
				way_rank[s][w]  = w;
			end
		cur_shift   = 4'd6;
		cur_penalty = 16'd20;
	endfunction

	// Look up one access, update tags, dirty bits and LRU ranks, return the result word
	function automatic resp_t lookup_access(req_t a);
		resp_t            r;
		logic [AddrW-1:0] line;
		int               set;
		int               way;
		int unsigned      old_rank;
		line = a.byte_addr >> cur_shift;
		set  = line % SETS;
		way  = -1;
		r    = '0;
		for (int w = 0; w < WAYS; w++)
			if (way < 0 && way_valid[set][w] && way_tag[set][w] == line)
				way = w;
		r.hit = (way >= 0);
		if (way < 0) begin
			// miss: replace the least recently used way
			way = 0;
			for (int w = 0; w < WAYS; w++)
				if (way_rank[set][w] == WAYS - 1)
					way = w;
			if (way_valid[set][way] && way_dirty[set][way]) begin
				r.dirty_evict = 1'b1;
				r.victim_line = way_tag[set][way];
			end
			way_tag[set][way]   = line;
			way_valid[set][way] = 1'b1;
			way_dirty[set][way] = 1'b0;
			way_ready[set][way] = a.now_cycle + AddrW'(cur_penalty);   // wraps at 48 bits
		end
		old_rank = way_rank[set][way];
		for (int w = 0; w < WAYS; w++)
			if (way_rank[set][w] < old_rank)
				way_rank[set][w]++;
		way_rank[set][way] = 0;
		if (a.is_store)
			way_dirty[set][way] = 1'b1;
		r.ready_cycle = way_ready[set][way];
		return r;
	endfunction

	// Result checker: the block cannot be stalled, so every done cycle carries a word
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_resp.size() == 0) begin
				$error("result word with nothing outstanding");
				errors++;
			end else begin
				resp_t exp_r;
				exp_r = pending_resp.pop_front();
				if (resp.ready_cycle !== exp_r.ready_cycle) begin
					$error("ready_cycle: expected %h, got %h", exp_r.ready_cycle,
						resp.ready_cycle);
					errors++;
				end
				if (resp.hit !== exp_r.hit) begin
					$error("hit: expected %b, got %b", exp_r.hit, resp.hit);
					errors++;
				end
				if (resp.dirty_evict !== exp_r.dirty_evict) begin
					$error("dirty_evict: expected %b, got %b", exp_r.dirty_evict,
						resp.dirty_evict);
					errors++;
				end
				if (resp.victim_line !== exp_r.victim_line) begin
					$error("victim_line: expected %h, got %h", exp_r.victim_line,
						resp.victim_line);
					errors++;
				end
			end
		end
	end

	// Watchdog: any accepted word or result counts as progress
	always @(posedge clk) begin
		if ((start && !busy && arst_n) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_dcache_lru_writeback_timing NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hand one access word over; start is left high so a following word goes back to back
	task automatic send_word(input logic [AddrW-1:0] now_c, input logic [AddrW-1:0] addr,
			input logic st);
		req_t a;
		a.now_cycle = now_c;
		a.byte_addr = addr;
		a.is_store  = st;
		start <= 1'b1;
		req   <= a;
		do
			@(posedge clk);
		while (busy);
		pending_resp.push_back(lookup_access(a));
	endtask

	// Sender goes idle (ends a burst); a zero gap leaves start as it is
	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
		drain();
		repeat (4) @(posedge clk);   // let the last access finish its row write
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LINE_SHIFT)
			cur_shift = val[3:0];
		else
			cur_penalty = val;
	endtask

	// Address built from a small pool of lines so that sets fill, hit and evict
	function automatic logic [AddrW-1:0] pooled_addr();
		logic [AddrW-1:0] line;
		logic [AddrW-1:0] low;
		line = (AddrW'($urandom_range(0, 9)) << 8) | AddrW'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			line = line | (AddrW'($urandom_range(0, 255)) << 20);
		low = {$urandom, $urandom};
		low = low & ((AddrW'(1) << cur_shift) - 1);
		return (line << cur_shift) | low;
	endfunction

	// Directed: default setting, set conflicts, hits, dirty eviction, field extremes
	task automatic test_default_setting();
		logic [AddrW-1:0] stride;
		stride = AddrW'(SETS) << 6;   // same set, next tag at line shift 6
		send_word(48'd100, 48'd0, 1'b1);
		send_word(48'd101, 48'd63, 1'b0);              // hit on the same line
		for (int i = 1; i < WAYS; i++)
			send_word(48'd102 + i, stride * i, 1'b0);
		send_word(48'd200, stride * WAYS, 1'b0);       // evicts the dirty line 0
		send_word(48'd201, 48'd0, 1'b0);               // refill, clean victim
		idle_for(3);
		send_word('1, '1, 1'b1);                       // ready wraps past 2^48
		send_word('1, '1, 1'b0);
		send_word(48'h0, 48'h5555_5555_5555, 1'b1);
		send_word(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b1);
		send_word(48'h5555_5555_5555, 48'h5555_5555_5555 ^ (stride * 7), 1'b0);
		idle_for(1);
	endtask

	// Directed: extremes of both registers
	task automatic test_register_extremes();
		write_reg(CFG_LINE_SHIFT, 16'd0);
		write_reg(CFG_MISS_PENALTY, 16'hFFFF);
		send_word(48'hFFFF_FFFF_0000, 48'd5, 1'b1);
		send_word(48'd1, 48'd5 + SETS, 1'b0);
		send_word(48'd2, 48'd5, 1'b0);
		write_reg(CFG_LINE_SHIFT, 16'hFFFF);            // upper bits ignored, shift 15
		write_reg(CFG_MISS_PENALTY, 16'd0);
		send_word(48'd7, '1, 1'b1);
		send_word(48'd8, 48'h7FFF, 1'b0);
		write_reg(CFG_LINE_SHIFT, 16'd2);
		send_word(48'd9, 48'd4, 1'b1);
		write_reg(CFG_LINE_SHIFT, 16'd12);
		send_word(48'd10, 48'h1000, 1'b0);
		idle_for(1);
	endtask

	// Random: bursts of pooled and fully random accesses over several settings
	task automatic test_random_traffic();
		logic [AddrW-1:0] now_c;
		logic [AddrW-1:0] addr;
		int               burst;
		now_c = {$urandom, $urandom};
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				write_reg(CFG_LINE_SHIFT, CfgW'($urandom_range(0, 15)));
				write_reg(CFG_MISS_PENALTY, (phase == 3) ? 16'hFFFF : CfgW'($urandom));
			end
			for (int n = 0; n < 340; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++, n++) begin
					now_c = now_c + AddrW'($urandom_range(0, 40));
					if ($urandom_range(0, 9) == 0)
						now_c = {$urandom, $urandom};
					addr = ($urandom_range(0, 7) == 0) ? AddrW'({$urandom, $urandom})
						: pooled_addr();
					send_word(now_c, addr, 1'($urandom));
				end
				if (n > 150 && n < 163)
					drain();   // sender waits for every owed result at least once per phase
				else if ($urandom_range(0, 3) != 0)
					idle_for($urandom_range(0, 7));
			end
		end
		drain();
	endtask

	initial begin
		errors   = 0;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = 1'b0;
		cfg_data = '0;
		start    = 1'b0;
		req      = '0;
		quiet_cycles = 0;
		clear_cache();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);   // clearing pass
		test_default_setting();
		test_register_extremes();
		test_random_traffic();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_dcache_lru_writeback_timing OK");
		else
			$display("tb_dcache_lru_writeback_timing NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/core/dclru_pkg.sv
rtl/core/dclru_ram.sv
rtl/core/dclru_ctrl.sv
rtl/core/dclru_dp.sv
rtl/core/dcache_lru_writeback_timing.sv
dv/tb_dcache_lru_writeback_timing.sv
